// ===== hdl/sv39ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared widths, codes and types of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

    // field widths
    localparam int VA_W      = 39;
    localparam int PA_W      = 56;
    localparam int PPN_W     = 44;
    localparam int ENTRY_W   = 54;
    localparam int SLOT_W    = 12;
    localparam int VPN_W     = 9;
    localparam int LEVEL_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int PAGE_SHIFT = 12;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = PPN_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_TABLE_PAGE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STORE_BASE_PAGE = 1'd1;

    // request operation codes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // walk levels
    localparam logic [LEVEL_W-1:0] LVL_PAGE = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MEGA = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_GIGA = 2'd2;

    // page offset masks per leaf level (12, 21 and 30 bits)
    localparam logic [PA_W-1:0] OFS_MASK_PAGE = {{(PA_W-12){1'b0}}, {12{1'b1}}};
    localparam logic [PA_W-1:0] OFS_MASK_MEGA = {{(PA_W-21){1'b0}}, {21{1'b1}}};
    localparam logic [PA_W-1:0] OFS_MASK_GIGA = {{(PA_W-30){1'b0}}, {30{1'b1}}};

    // entry bit positions
    localparam int PTE_V       = 0;
    localparam int PTE_PPN_LSB = 10;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED   = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_BRANCH0  = 2'd2,
        ST_OUTSIDE  = 2'd3
    } walk_status_t;

endpackage

// ===== hdl/sv39ptw_if.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_if
// Valid/ready channels of the walker: request beats and response beats.
// ----------------------------------------------------------------------------
interface sv39ptw_req_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [sv39ptw_pkg::SLOT_W-1:0]       entry_slot;
    logic [sv39ptw_pkg::ENTRY_W-1:0]      entry_word;
    logic [sv39ptw_pkg::VA_W-1:0]         virtual_address;

    modport source (
        output valid, operation, entry_slot, entry_word, virtual_address,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_slot, entry_word, virtual_address,
        output ready
    );

endinterface

interface sv39ptw_rsp_if;

    logic                                 valid;
    logic                                 ready;
    logic [sv39ptw_pkg::PA_W-1:0]         physical_address;
    logic [sv39ptw_pkg::LEVEL_W-1:0]      leaf_level;
    logic [sv39ptw_pkg::STATUS_W-1:0]     walk_status;

    modport source (
        output valid, physical_address, leaf_level, walk_status,
        input  ready
    );

    modport sink (
        input  valid, physical_address, leaf_level, walk_status,
        output ready
    );

endinterface

// ===== hdl/sv39ptw_ram.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sv39ptw_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sv39_page_table_walker_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker_core
// Three-level Sv39 walker over a local store of page-table entry words.
// ----------------------------------------------------------------------------
// A write beat puts one entry word into the store when its slot lies within it. A
// translate beat walks from the root table down to level 0, one store read
// per level; the store has a single registered read port, so a translation
// holds the walker until its last level read has returned, and it reads no
// entry at all when the root table lies outside the store. The
// finished result sits in an output register, so the next request is taken
// while it waits; the walker stalls only when a second result is done before
// the first is taken. The store needs no clearing after reset: an entry must
// be written before a walk reads it. The store holds the first STORE_TABLES
// tables up to the reach of the 12-bit slot index (eight tables).
// ----------------------------------------------------------------------------
module sv39_page_table_walker_core #(
    parameter int STORE_TABLES = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sv39ptw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]    cfg_data,
    sv39ptw_req_if.sink                           req,
    sv39ptw_rsp_if.source                         rsp
);

    localparam int TABLE_ENTRIES = 512;
    localparam int unsigned STORE_WORDS = STORE_TABLES * TABLE_ENTRIES;
    localparam int SLOT_TABLES = (1 << sv39ptw_pkg::SLOT_W) / TABLE_ENTRIES;
    localparam int MEM_TABLES  = (STORE_TABLES < SLOT_TABLES) ? STORE_TABLES : SLOT_TABLES;
    localparam int MEM_WORDS   = MEM_TABLES * TABLE_ENTRIES;
    localparam int ADDR_W      = $clog2(MEM_WORDS);
    localparam int REL_W       = 10;
    localparam int WORD_W      = REL_W + sv39ptw_pkg::VPN_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [sv39ptw_pkg::PPN_W-1:0]   root_reg;
    logic [sv39ptw_pkg::PPN_W-1:0]   base_reg;
    logic [sv39ptw_pkg::VA_W-1:0]    va_reg, va_next;
    logic [sv39ptw_pkg::LEVEL_W-1:0] level_reg, level_next;

    logic                              out_valid_reg, out_valid_next;
    logic [sv39ptw_pkg::PA_W-1:0]      out_pa_reg, out_pa_next;
    logic [sv39ptw_pkg::LEVEL_W-1:0]   out_lvl_reg, out_lvl_next;
    sv39ptw_pkg::walk_status_t         out_st_reg, out_st_next;

    logic [sv39ptw_pkg::PA_W-1:0]      pend_pa_reg, pend_pa_next;
    logic [sv39ptw_pkg::LEVEL_W-1:0]   pend_lvl_reg, pend_lvl_next;
    sv39ptw_pkg::walk_status_t         pend_st_reg, pend_st_next;

    logic                              accept;
    logic                              out_free;

    // entry lookup shared by the root step and every later level
    logic [sv39ptw_pkg::PPN_W-1:0]     lk_pg;
    logic [sv39ptw_pkg::LEVEL_W-1:0]   lk_lvl;
    logic [sv39ptw_pkg::VA_W-1:0]      lk_va;
    logic [sv39ptw_pkg::VPN_W-1:0]     lk_idx;
    logic [sv39ptw_pkg::PPN_W-1:0]     lk_rel;
    logic                              lk_outside;
    logic [WORD_W-1:0]                 lk_word;

    // store access
    logic                              mem_we;
    logic                              mem_re;
    logic [sv39ptw_pkg::ENTRY_W-1:0]   mem_rdata;

    // entry decode
    logic [sv39ptw_pkg::PPN_W-1:0]     ent_ppn;
    logic                              ent_valid;
    logic                              ent_leaf;
    logic [sv39ptw_pkg::PA_W-1:0]      ofs_mask;
    logic [sv39ptw_pkg::PA_W-1:0]      leaf_pa;

    // walk end
    logic                              fin;
    logic [sv39ptw_pkg::PA_W-1:0]      fin_pa;
    logic [sv39ptw_pkg::LEVEL_W-1:0]   fin_lvl;
    sv39ptw_pkg::walk_status_t         fin_st;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sv39ptw_pkg::CFG_ROOT_TABLE_PAGE: root_reg <= cfg_data;
                sv39ptw_pkg::CFG_STORE_BASE_PAGE: base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // lookup: pick table page and index, check the table lies in the store
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            lk_pg  = root_reg;
            lk_lvl = sv39ptw_pkg::LVL_GIGA;
            lk_va  = req.virtual_address;
        end
        else
        begin
            lk_pg  = ent_ppn;
            lk_lvl = level_reg - 2'd1;
            lk_va  = va_reg;
        end
        unique case (lk_lvl)
            sv39ptw_pkg::LVL_GIGA: lk_idx = lk_va[38:30];
            sv39ptw_pkg::LVL_MEGA: lk_idx = lk_va[29:21];
            default:               lk_idx = lk_va[20:12];
        endcase
        lk_rel     = lk_pg - base_reg;
        lk_outside = (lk_pg < base_reg) ||
                     (lk_rel >= sv39ptw_pkg::PPN_W'(STORE_TABLES));
        lk_word    = {lk_rel[REL_W-1:0], lk_idx};
    end

    // entry decode and leaf address
    always_comb
    begin
        ent_ppn   = mem_rdata[sv39ptw_pkg::PTE_PPN_LSB +: sv39ptw_pkg::PPN_W];
        ent_valid = mem_rdata[sv39ptw_pkg::PTE_V];
        ent_leaf  = |mem_rdata[3:1];
        unique case (level_reg)
            sv39ptw_pkg::LVL_GIGA: ofs_mask = sv39ptw_pkg::OFS_MASK_GIGA;
            sv39ptw_pkg::LVL_MEGA: ofs_mask = sv39ptw_pkg::OFS_MASK_MEGA;
            default:               ofs_mask = sv39ptw_pkg::OFS_MASK_PAGE;
        endcase
        leaf_pa = ({ent_ppn, {sv39ptw_pkg::PAGE_SHIFT{1'b0}}} & ~ofs_mask) |
                  (sv39ptw_pkg::PA_W'(va_reg) & ofs_mask);
    end

    // walk step: end the walk or issue the next level read
    always_comb
    begin
        fin     = 1'b0;
        fin_pa  = '0;
        fin_lvl = sv39ptw_pkg::LVL_PAGE;
        fin_st  = sv39ptw_pkg::ST_UNMAPPED;
        mem_re  = 1'b0;
        mem_we  = accept && (req.operation == sv39ptw_pkg::OP_WRITE) &&
                  (32'(req.entry_slot) < STORE_WORDS);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.operation == sv39ptw_pkg::OP_TRANSLATE))
                begin
                    if (lk_outside)
                    begin
                        fin    = 1'b1;
                        fin_st = sv39ptw_pkg::ST_OUTSIDE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                priority if (!ent_valid)
                begin
                    fin    = 1'b1;
                    fin_st = sv39ptw_pkg::ST_UNMAPPED;
                end
                else if (ent_leaf)
                begin
                    fin     = 1'b1;
                    fin_pa  = leaf_pa;
                    fin_lvl = level_reg;
                    fin_st  = sv39ptw_pkg::ST_MAPPED;
                end
                else if (level_reg == sv39ptw_pkg::LVL_PAGE)
                begin
                    fin    = 1'b1;
                    fin_st = sv39ptw_pkg::ST_BRANCH0;
                end
                else if (lk_outside)
                begin
                    fin    = 1'b1;
                    fin_st = sv39ptw_pkg::ST_OUTSIDE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // sequencer and result registers
    always_comb
    begin
        state_next     = state_reg;
        va_next        = va_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        out_pa_next    = out_pa_reg;
        out_lvl_next   = out_lvl_reg;
        out_st_next    = out_st_reg;
        pend_pa_next   = pend_pa_reg;
        pend_lvl_next  = pend_lvl_reg;
        pend_st_next   = pend_st_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (mem_re)
        begin
            level_next = lk_lvl;
            state_next = S_WALK;
        end
        if (state_reg == S_IDLE)
        begin
            va_next = req.virtual_address;
        end

        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_pa_next    = fin_pa;
                out_lvl_next   = fin_lvl;
                out_st_next    = fin_st;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_pa_next  = fin_pa;
                pend_lvl_next = fin_lvl;
                pend_st_next  = fin_st;
                state_next    = S_DONE;
            end
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_pa_next    = pend_pa_reg;
            out_lvl_next   = pend_lvl_reg;
            out_st_next    = pend_st_reg;
            state_next     = S_IDLE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        va_reg       <= va_next;
        level_reg    <= level_next;
        out_pa_reg   <= out_pa_next;
        out_lvl_reg  <= out_lvl_next;
        out_st_reg   <= out_st_next;
        pend_pa_reg  <= pend_pa_next;
        pend_lvl_reg <= pend_lvl_next;
        pend_st_reg  <= pend_st_next;
    end

    // entry store
    sv39ptw_ram #(
        .WIDTH (sv39ptw_pkg::ENTRY_W),
        .DEPTH (MEM_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (req.entry_slot[ADDR_W-1:0]),
        .wdata (req.entry_word),
        .re    (mem_re),
        .raddr (lk_word[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    // response beat
    assign rsp.valid            = out_valid_reg;
    assign rsp.physical_address = out_pa_reg;
    assign rsp.leaf_level       = out_lvl_reg;
    assign rsp.walk_status      = out_st_reg;

endmodule
